>>> hw/rtl/drlr_pkg.sv
// shared types, codes and reset values for the distinctive ring line router
package drlr_pkg;

  localparam int SampleW  = 4;
  localparam int InDataW  = 8;
  localparam int OutDataW = 16;
  localparam int CfgDataW = 16;
  localparam int CfgAddrW = 3;

  typedef enum logic [3:0] {
    PH_PAUSE      = 4'd0,
    PH_IDLE_READ  = 4'd1,
    PH_RING_ON    = 4'd2,
    PH_RING_GAP   = 4'd3,
    PH_RING_CLEAR = 4'd4,
    PH_HANGUP     = 4'd5,
    PH_OUT_PAUSE  = 4'd6,
    PH_OUT_WAIT   = 4'd7,
    PH_TONE       = 4'd8
  } phase_t;

  typedef enum logic [CfgAddrW-1:0] {
    REG_SETTLE_TICKS     = 3'd0,
    REG_PAUSE_TICKS      = 3'd1,
    REG_RING_GAP_READS   = 3'd2,
    REG_RING_CLEAR_READS = 3'd3,
    REG_HANGUP_READS     = 3'd4,
    REG_BUSY_CADENCE     = 3'd5,
    REG_TONE_CYCLES      = 3'd6,
    REG_TONE_HALF_TICKS  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] settle_ticks;
    logic [15:0] pause_ticks;
    logic [7:0]  ring_gap_reads;
    logic [7:0]  ring_clear_reads;
    logic [7:0]  hangup_reads;
    logic [7:0]  busy_cadence;
    logic [9:0]  tone_cycles;
    logic [7:0]  tone_half_ticks;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    settle_ticks:     16'd600,
    pause_ticks:      16'd1000,
    ring_gap_reads:   8'd12,
    ring_clear_reads: 8'd100,
    hangup_reads:     8'd25,
    busy_cadence:     8'd8,
    tone_cycles:      10'd150,
    tone_half_ticks:  8'd15
  };

  // head of the sample queue as seen by the controller
  typedef struct packed {
    logic               valid;
    logic [SampleW-1:0] sample;
  } q_head_t;

  typedef struct packed {
    phase_t      resume_phase;
    logic [3:0]  line_mask;
    logic [3:0]  rings;
    logic [7:0]  read_loop_count;
    logic [7:0]  cadence_count;
    logic [3:0]  settle_value;
    logic        ring_latch;
    logic [15:0] settle_count;
    logic [15:0] wait_count;
    logic [9:0]  tone_period_count;
    logic [7:0]  tone_half_count;
    logic        tone_high;
  } ctx_t;

  localparam ctx_t CtxReset = '{
    resume_phase:      PH_PAUSE,
    line_mask:         4'h0,
    rings:             4'h0,
    read_loop_count:   8'h00,
    cadence_count:     8'h00,
    settle_value:      4'hF,
    ring_latch:        1'b1,
    settle_count:      16'h0000,
    wait_count:        16'h0000,
    tone_period_count: 10'h000,
    tone_half_count:   8'h00,
    tone_high:         1'b0
  };

endpackage

>>> hw/rtl/distinctive_ring_line_router_unit.sv
// top level of the distinctive ring line router: config registers, queue and controller
//
// One raw line sample per cycle goes in on the s_ side and one result per sample comes
// out on the m_ side; the sustained rate is one sample per clock while the output is not
// stalled. A sample is held in a two-entry queue, then the controller debounces it, steps
// the call sequencer combinationally and registers the result, so each sample passes through
// its queue entry and then the result register to the m_ side. While the output is
// stalled the queue keeps taking samples until both entries are filled; once it is full
// the input stays blocked through the cycle in which the controller frees an entry.
// Registers are written through cfg_we/cfg_addr/cfg_data with the index order settle,
// pause, ring gap, ring clear, hang-up, busy cadence, tone cycles and tone half period,
// and must only be written while no result is outstanding.
module distinctive_ring_line_router_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [drlr_pkg::InDataW-1:0]   s_tdata,  // [3:0] port_sample
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [drlr_pkg::OutDataW-1:0]  m_tdata,  // [2:0] relay_mask, [3] tone,
                                                   // [7:4] phase, [11:8] ring_count
  input  logic                           cfg_we,
  input  logic [drlr_pkg::CfgAddrW-1:0]  cfg_addr,
  input  logic [drlr_pkg::CfgDataW-1:0]  cfg_data
);
  import drlr_pkg::*;

  cfg_t    cfg;
  q_head_t head;
  logic    pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CfgReset;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_SETTLE_TICKS:     cfg.settle_ticks     <= cfg_data;
        REG_PAUSE_TICKS:      cfg.pause_ticks      <= cfg_data;
        REG_RING_GAP_READS:   cfg.ring_gap_reads   <= cfg_data[7:0];
        REG_RING_CLEAR_READS: cfg.ring_clear_reads <= cfg_data[7:0];
        REG_HANGUP_READS:     cfg.hangup_reads     <= cfg_data[7:0];
        REG_BUSY_CADENCE:     cfg.busy_cadence     <= cfg_data[7:0];
        REG_TONE_CYCLES:      cfg.tone_cycles      <= cfg_data[9:0];
        REG_TONE_HALF_TICKS:  cfg.tone_half_ticks  <= cfg_data[7:0];
        default:              cfg <= cfg;
      endcase
    end
  end

  drlr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_sample (s_tdata[SampleW-1:0]),
    .head     (head),
    .pop      (pop)
  );

  drlr_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // tone only sounds in the tone phase
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3] |-> m_tdata[7:4] == PH_TONE)
    else $error("tone high outside tone phase");

  // relays stay open before a call is set up
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[7:4] == PH_PAUSE || m_tdata[7:4] == PH_IDLE_READ ||
                 m_tdata[7:4] == PH_RING_ON || m_tdata[7:4] == PH_RING_GAP)
    |-> m_tdata[2:0] == 3'b000)
    else $error("relay closed outside a call");

  // the controller only consumes a queued sample
  assert property (@(posedge clk) disable iff (rst) pop |-> head.valid)
    else $error("pop from empty queue");

  // a result held under backpressure is not overwritten
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

>>> hw/rtl/drlr_queue.sv
// two-entry sample queue between the stream input and the line controller
module drlr_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [drlr_pkg::SampleW-1:0]  s_sample,
  output drlr_pkg::q_head_t             head,
  input  logic                          pop
);
  import drlr_pkg::*;

  logic [SampleW-1:0] mem [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         fill;
  logic               push;

  assign s_tready    = (fill != 2'd2);
  assign push        = s_tvalid && s_tready;
  assign head.valid  = (fill != 2'd0);
  assign head.sample = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= s_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> hw/rtl/drlr_core.sv
// debounce, call sequencing, busy tone timing and result register
module drlr_core (
  input  logic                           clk,
  input  logic                           rst,
  input  drlr_pkg::cfg_t                 cfg,
  input  drlr_pkg::q_head_t              head,
  output logic                           pop,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [drlr_pkg::OutDataW-1:0]  m_tdata
);
  import drlr_pkg::*;

  phase_t      phase;
  phase_t      phase_next;
  ctx_t        ctx;
  ctx_t        ctx_next;

  logic [3:0]  s;
  logic [3:0]  rd;
  logic        rd_done;
  logic [3:0]  lm_new;
  logic        chk;
  logic        hit;
  logic [7:0]  limit;
  logic        busy;
  phase_t      nxt;
  logic [7:0]  rlc_n;
  logic [7:0]  cad_n;
  logic [7:0]  half_inc;
  logic [10:0] per_inc;
  logic [2:0]  relay;

  assign s   = head.sample;
  assign pop = head.valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_PAUSE;
      ctx   <= CtxReset;
    end else if (pop) begin
      phase <= phase_next;
      ctx   <= ctx_next;
    end
  end

  always_comb begin
    phase_next = phase;
    ctx_next   = ctx;
    rd         = 4'h0;
    rd_done    = 1'b0;
    lm_new     = 4'h0;
    chk        = 1'b0;
    hit        = 1'b0;
    limit      = 8'h00;
    busy       = 1'b0;
    nxt        = phase;
    rlc_n      = 8'h00;
    cad_n      = 8'h00;
    half_inc   = ctx.tone_half_count + 8'd1;
    per_inc    = {1'b0, ctx.tone_period_count} + 11'd1;
    case (phase)
      PH_PAUSE, PH_OUT_PAUSE: begin
        if ({1'b0, ctx.wait_count} + 17'd1 >= {1'b0, cfg.pause_ticks}) begin
          ctx_next.wait_count      = 16'h0000;
          ctx_next.read_loop_count = 8'h00;
          phase_next = (phase == PH_PAUSE) ? PH_IDLE_READ : PH_OUT_WAIT;
        end else begin
          ctx_next.wait_count = ctx.wait_count + 16'd1;
        end
      end
      PH_TONE: begin
        if (half_inc >= cfg.tone_half_ticks) begin
          ctx_next.tone_half_count = 8'h00;
          if (ctx.tone_high) begin
            ctx_next.tone_high = 1'b0;
          end else if (per_inc >= {1'b0, cfg.tone_cycles}) begin
            ctx_next.tone_period_count = 10'h000;
            ctx_next.wait_count        = 16'h0000;
            phase_next = ctx.resume_phase;
          end else begin
            ctx_next.tone_period_count = per_inc[9:0];
            ctx_next.tone_high         = 1'b1;
          end
        end else begin
          ctx_next.tone_half_count = half_inc;
        end
      end
      default: begin
        // debounced read
        if (ctx.settle_count == 16'h0000) begin
          ctx_next.settle_value = s;
          ctx_next.ring_latch   = s[0];
          ctx_next.settle_count = 16'd1;
        end else if (s != ctx.settle_value) begin
          ctx_next.settle_value = s;
          ctx_next.ring_latch   = ctx.ring_latch & s[0];
          ctx_next.settle_count = 16'd1;
        end else if (ctx.settle_count >= cfg.settle_ticks) begin
          rd = ctx.settle_value & {3'b111, ctx.ring_latch};
          ctx_next.settle_count = 16'h0000;
          rd_done = 1'b1;
        end else begin
          ctx_next.settle_count = ctx.settle_count + 16'd1;
        end
        if (rd_done) begin
          case (phase)
            PH_IDLE_READ: begin
              lm_new = ~rd;
              ctx_next.line_mask = lm_new;
              if (lm_new[0]) begin
                ctx_next.rings = 4'd1;
                phase_next = PH_RING_ON;
              end else if (lm_new[3:1] != 3'b000) begin
                ctx_next.wait_count = 16'h0000;
                phase_next = PH_OUT_PAUSE;
              end else begin
                ctx_next.wait_count = 16'h0000;
                phase_next = PH_PAUSE;
              end
            end
            PH_RING_ON: begin
              if (rd[0]) begin
                ctx_next.read_loop_count = 8'h00;
                phase_next = PH_RING_GAP;
              end
            end
            PH_RING_GAP: begin
              if (!rd[0]) begin
                if (ctx.rings != 4'd15) begin
                  ctx_next.rings = ctx.rings + 4'd1;
                end
                phase_next = PH_RING_ON;
              end else if (ctx.read_loop_count >= cfg.ring_gap_reads) begin
                ctx_next.read_loop_count = 8'h00;
                if (ctx.rings inside {[4'd1:4'd3]}) begin
                  ctx_next.line_mask = 4'b0001 << ctx.rings[1:0];
                  phase_next = PH_RING_CLEAR;
                end else begin
                  ctx_next.wait_count = 16'h0000;
                  phase_next = PH_PAUSE;
                end
              end else begin
                ctx_next.read_loop_count = ctx.read_loop_count + 8'd1;
              end
            end
            PH_RING_CLEAR, PH_HANGUP, PH_OUT_WAIT: begin
              chk   = (phase == PH_RING_CLEAR);
              hit   = chk ? !rd[0] : ((~rd & ctx.line_mask) != 4'h0);
              limit = chk ? cfg.ring_clear_reads : cfg.hangup_reads;
              busy  = ((~rd[3:1] & ~ctx.line_mask[3:1]) != 3'b000);
              rlc_n = hit ? 8'd1 : ctx.read_loop_count + 8'd1;
              nxt   = phase;
              if (rlc_n >= limit) begin
                rlc_n = 8'h00;
                ctx_next.wait_count = 16'h0000;
                nxt = chk ? PH_HANGUP : PH_PAUSE;
              end
              ctx_next.read_loop_count = rlc_n;
              phase_next = nxt;
              if (busy) begin
                cad_n = ctx.cadence_count + 8'd1;
                if (cad_n >= cfg.busy_cadence) begin
                  cad_n = 8'h00;
                  ctx_next.resume_phase      = nxt;
                  ctx_next.tone_high         = 1'b1;
                  ctx_next.tone_half_count   = 8'h00;
                  ctx_next.tone_period_count = 10'h000;
                  phase_next = PH_TONE;
                end
                ctx_next.cadence_count = cad_n;
              end
            end
            default: begin
              ctx_next.wait_count = 16'h0000;
              phase_next = PH_PAUSE;
            end
          endcase
        end
      end
    endcase
  end

  assign relay = (phase_next inside {[PH_RING_CLEAR:PH_TONE]}) ?
                 ctx_next.line_mask[3:1] : 3'b000;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= {4'h0, ctx_next.rings, phase_next,
                  (phase_next == PH_TONE) && ctx_next.tone_high, relay};
    end
  end

endmodule
